FILE: hw/rtl/erx_pkg.sv
// erx_pkg: constants, tables and types for the single-precision exp pipeline.
// Used by exp_range_reduced_series and erx_chk; no dependencies.
package erx_pkg;

    localparam int FRAC_BITS    = 30;
    localparam int SERIES_TERMS = 8;
    localparam int N_MUL        = SERIES_TERMS - 1;
    localparam int SUM_W        = FRAC_BITS + 4;

    localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;
    localparam logic [31:0] INF_BITS  = 32'h7F80_0000;
    localparam logic [31:0] ONE_BITS  = 32'h3F80_0000;
    localparam logic [31:0] F88_BITS  = 32'h42B0_0000;

    // ln2 in Q0.30, truncated
    localparam logic [29:0] LN2_Q     = 30'h2C5C_85FD;
    localparam logic [29:0] HALF_LN2  = 30'((LN2_Q + 30'd1) / 2);
    // floor(2^41 / ln2_q): quotient estimate, low by at most one
    localparam logic [11:0] RECIP_LN2 = 12'd2954;
    localparam logic [7:0]  FIX_EXP   = 8'(150 - FRAC_BITS);

    // floor(2^32 / n) for n = 2 .. SERIES_TERMS
    localparam logic [31:0] INV_TAB [N_MUL] = '{
        32'h8000_0000, 32'h5555_5555, 32'h4000_0000, 32'h3333_3333,
        32'h2AAA_AAAA, 32'h2492_4924, 32'h2000_0000
    };

    typedef struct packed {
        logic              spec;
        logic [31:0]       sval;
        logic signed [7:0] k;
    } t_side;

endpackage

FILE: hw/rtl/exp_range_reduced_series.sv
// exp_range_reduced_series: single-precision exp(x), fully pipelined.
// Depends on erx_pkg.
//
// Usage:
//  Input channel i_valid/o_ready carries one IEEE single value per beat on
//  i_x_bits; output channel o_valid/i_ready returns exp(x) on o_result_bits.
//  A beat is taken whenever valid and ready are both high.
//  Throughput: one beat per cycle while the output is not stalled; 28 register
//  stages (range reduction, three stages per series term, normalize, output register).
//  Specials: NaN gives 0x7FC00000, x > 88 gives +inf, x < -88 gives +0,
//  zero gives 1.0, underflowed results flush to +0.
//  Stall: when the output is held, every stage holds together and o_ready
//  drops; no beat is lost or repeated.
//  Reset (i_rst_n low, synchronous) clears all valid bits; beats in flight
//  are dropped.
module exp_range_reduced_series (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_x_bits,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_result_bits
);
    import erx_pkg::*;

    logic w_en;

    // stage 1: specials, fixed-point conversion
    logic [30:0] w_mag;
    logic [7:0]  w_ef;
    logic [23:0] w_sig;
    logic [36:0] w_m;
    t_side       w_side1;

    logic        r_s1v, r_s1neg;
    t_side       r_s1side;
    logic [36:0] r_s1m;

    logic [38:0] w_n;
    logic [40:0] w_qp;
    logic        r_s2v, r_s2neg;
    t_side       r_s2side;
    logic [36:0] r_s2m;
    logic [6:0]  r_s2q;

    logic        r_s3v, r_s3neg;
    t_side       r_s3side;
    logic [36:0] r_s3m, r_s3prod;
    logic [6:0]  r_s3q;

    logic        r_s4v, r_s4neg;
    t_side       r_s4side;
    logic [38:0] r_s4d;
    logic [6:0]  r_s4q;

    logic             w_up, w_rneg, w_rsign;
    logic [38:0]      w_rr;
    logic [7:0]       w_kq;
    logic [29:0]      w_rmag;
    logic [SUM_W-1:0] w_sum0;
    t_side            w_side5;

    logic             r_s5v, r_s5rs;
    t_side            r_s5side;
    logic [29:0]      r_s5rm;
    logic [SUM_W-1:0] r_s5sum;

    // series term pipeline
    logic             w_tv    [N_MUL+1];
    t_side            w_tside [N_MUL+1];
    logic [29:0]      w_trm   [N_MUL+1];
    logic             w_trs   [N_MUL+1];
    logic [SUM_W-1:0] w_tsum  [N_MUL+1];
    logic [29:0]      w_ttm   [N_MUL+1];
    logic             w_tts   [N_MUL+1];

    logic             r_av [N_MUL], r_bv [N_MUL], r_cv [N_MUL];
    t_side            r_aside [N_MUL], r_bside [N_MUL], r_cside [N_MUL];
    logic [29:0]      r_arm [N_MUL], r_brm [N_MUL], r_crm [N_MUL];
    logic             r_ars [N_MUL], r_brs [N_MUL], r_crs [N_MUL];
    logic [SUM_W-1:0] r_asum [N_MUL], r_bsum [N_MUL], r_csum [N_MUL];
    logic             r_ats [N_MUL], r_bts [N_MUL], r_cts [N_MUL];
    logic [59:0]      r_ap [N_MUL];
    logic [61:0]      r_bp [N_MUL];
    logic [29:0]      r_ctm [N_MUL];

    // normalize
    logic [SUM_W-1:0] w_us;
    logic [5:0]       w_p;
    logic             r_n1v, r_n1np;
    t_side            r_n1side;
    logic [SUM_W-1:0] r_n1us;
    logic [5:0]       r_n1p;

    logic [SUM_W-1:0]  w_shf;
    logic signed [9:0] w_e;
    logic [31:0]       w_res;
    logic              r_ov;
    logic [31:0]       r_out;

    assign w_en          = !r_ov || i_ready;
    assign o_ready       = w_en;
    assign o_valid       = r_ov;
    assign o_result_bits = r_out;

    always_comb begin
        w_mag = i_x_bits[30:0];
        w_ef  = i_x_bits[30:23];
        w_sig = {1'b1, i_x_bits[22:0]};
        if (w_ef == 8'd0) begin
            w_ef     = 8'd1;
            w_sig[23] = 1'b0;
        end
        if (w_ef >= FIX_EXP) begin
            w_m = {13'b0, w_sig} << (w_ef - FIX_EXP);
        end else begin
            w_m = {13'b0, w_sig} >> (FIX_EXP - w_ef);
        end
        w_side1.k = '0;
        w_side1.spec = 1'b1;
        if (w_mag > INF_BITS[30:0]) begin
            w_side1.sval = QNAN_BITS;
        end else if (w_mag == 31'd0) begin
            w_side1.sval = ONE_BITS;
        end else if (w_mag > F88_BITS[30:0]) begin
            w_side1.sval = i_x_bits[31] ? 32'd0 : INF_BITS;
        end else begin
            w_side1.spec = 1'b0;
            w_side1.sval = 32'd0;
        end
    end

    // k estimate from the top bits of 2|x| + ln2
    assign w_n  = {1'b0, r_s1m, 1'b0} + 39'(LN2_Q);
    assign w_qp = 41'(w_n[38:10]) * 41'(RECIP_LN2);

    always_comb begin
        w_up    = $signed(r_s4d) >= $signed({9'd0, HALF_LN2});
        w_rr    = w_up ? r_s4d - 39'(LN2_Q) : r_s4d;
        w_kq    = {1'b0, r_s4q} + 8'(w_up);
        w_rneg  = w_rr[38];
        w_rmag  = w_rneg ? 30'(-w_rr) : w_rr[29:0];
        w_rsign = w_rneg ^ r_s4neg;
        w_sum0  = w_rsign ? SUM_W'(1 << FRAC_BITS) - SUM_W'(w_rmag)
                          : SUM_W'(1 << FRAC_BITS) + SUM_W'(w_rmag);
        w_side5   = r_s4side;
        w_side5.k = r_s4neg ? -w_kq : w_kq;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1v <= 1'b0;
            r_s2v <= 1'b0;
            r_s3v <= 1'b0;
            r_s4v <= 1'b0;
            r_s5v <= 1'b0;
            r_n1v <= 1'b0;
            r_ov  <= 1'b0;
        end else if (w_en) begin
            r_s1v <= i_valid;
            r_s2v <= r_s1v;
            r_s3v <= r_s2v;
            r_s4v <= r_s3v;
            r_s5v <= r_s4v;
            r_n1v <= w_tv[N_MUL];
            r_ov  <= r_n1v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1side <= w_side1;
            r_s1neg  <= i_x_bits[31];
            r_s1m    <= w_m;

            r_s2side <= r_s1side;
            r_s2neg  <= r_s1neg;
            r_s2m    <= r_s1m;
            r_s2q    <= w_qp[38:32];

            r_s3side <= r_s2side;
            r_s3neg  <= r_s2neg;
            r_s3m    <= r_s2m;
            r_s3q    <= r_s2q;
            r_s3prod <= 37'(r_s2q) * 37'(LN2_Q);

            r_s4side <= r_s3side;
            r_s4neg  <= r_s3neg;
            r_s4q    <= r_s3q;
            r_s4d    <= {2'b0, r_s3m} - {2'b0, r_s3prod};

            r_s5side <= w_side5;
            r_s5rm   <= w_rmag;
            r_s5rs   <= w_rsign;
            r_s5sum  <= w_sum0;

            r_n1side <= w_tside[N_MUL];
            r_n1us   <= w_us;
            r_n1p    <= w_p;
            r_n1np   <= w_us[SUM_W-1] || (w_us == '0);

            r_out    <= w_res;
        end
    end

    assign w_tv[0]    = r_s5v;
    assign w_tside[0] = r_s5side;
    assign w_trm[0]   = r_s5rm;
    assign w_trs[0]   = r_s5rs;
    assign w_tsum[0]  = r_s5sum;
    assign w_ttm[0]   = r_s5rm;
    assign w_tts[0]   = r_s5rs;

    for (genvar j = 0; j < N_MUL; j++) begin : g_term
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_av[j] <= 1'b0;
                r_bv[j] <= 1'b0;
                r_cv[j] <= 1'b0;
            end else if (w_en) begin
                r_av[j] <= w_tv[j];
                r_bv[j] <= r_av[j];
                r_cv[j] <= r_bv[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_aside[j] <= w_tside[j];
                r_arm[j]   <= w_trm[j];
                r_ars[j]   <= w_trs[j];
                r_asum[j]  <= w_tsum[j];
                r_ats[j]   <= w_tts[j] ^ w_trs[j];
                r_ap[j]    <= 60'(w_ttm[j]) * 60'(w_trm[j]);

                r_bside[j] <= r_aside[j];
                r_brm[j]   <= r_arm[j];
                r_brs[j]   <= r_ars[j];
                r_bsum[j]  <= r_asum[j];
                r_bts[j]   <= r_ats[j];
                r_bp[j]    <= 62'(r_ap[j][59:30]) * 62'(INV_TAB[j]);

                r_cside[j] <= r_bside[j];
                r_crm[j]   <= r_brm[j];
                r_crs[j]   <= r_brs[j];
                r_cts[j]   <= r_bts[j];
                r_ctm[j]   <= r_bp[j][61:32];
                r_csum[j]  <= r_bts[j] ? r_bsum[j] - SUM_W'(r_bp[j][61:32])
                                       : r_bsum[j] + SUM_W'(r_bp[j][61:32]);
            end
        end

        assign w_tv[j+1]    = r_cv[j];
        assign w_tside[j+1] = r_cside[j];
        assign w_trm[j+1]   = r_crm[j];
        assign w_trs[j+1]   = r_crs[j];
        assign w_tsum[j+1]  = r_csum[j];
        assign w_ttm[j+1]   = r_ctm[j];
        assign w_tts[j+1]   = r_cts[j];
    end

    always_comb begin
        w_us = w_tsum[N_MUL];
        w_p  = '0;
        for (int i = 0; i < SUM_W; i++) begin
            if (w_us[i]) begin
                w_p = 6'(i);
            end
        end
    end

    always_comb begin
        w_shf = r_n1us << (6'(SUM_W - 1) - r_n1p);
        w_e   = $signed(10'(r_n1p)) - 10'sd30 + 10'sd127
              + $signed({{2{r_n1side.k[7]}}, r_n1side.k});
        if (r_n1side.spec) begin
            w_res = r_n1side.sval;
        end else if (r_n1np) begin
            w_res = 32'd0;
        end else if (w_e >= 10'sd255) begin
            w_res = INF_BITS;
        end else if (w_e <= 10'sd0) begin
            w_res = 32'd0;
        end else begin
            w_res = {1'b0, w_e[7:0], w_shf[SUM_W-2 -: 23]};
        end
    end

endmodule

FILE: hw/rtl/erx_chk.sv
// erx_chk: port-level checks for exp_range_reduced_series, bound to the top.
// Depends on erx_pkg.
module erx_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [31:0] o_result_bits
);
    import erx_pkg::*;

    a_rst_clear: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_result_bits))
        else $error("stalled beat changed");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready == (!o_valid || i_ready))
        else $error("input ready not tied to output room");

    a_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_result_bits[31])
        else $error("negative exp result");

    a_nan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result_bits[30:23] == 8'hFF && o_result_bits[22:0] != 23'd0
        |-> o_result_bits == QNAN_BITS)
        else $error("non-canonical NaN");

endmodule

bind exp_range_reduced_series erx_chk u_erx_chk (.*);

FILE: tb/testbench.sv
// testbench: self-checking bench for exp_range_reduced_series (fp32 exp pipeline).
// Depends on erx_pkg for special bit patterns; predicts each result in fixed point.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import erx_pkg::*;

    localparam int N_RANDOM   = 1950;
    localparam int WDOG_LIMIT = 20000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [31:0] i_x_bits;
    logic        o_valid;
    logic        i_ready;
    logic [31:0] o_result_bits;

    exp_range_reduced_series u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_x_bits(i_x_bits), .o_valid(o_valid), .i_ready(i_ready),
        .o_result_bits(o_result_bits)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    logic [31:0] exp_queue [$];
    int          n_err = 0;
    int          n_sent = 0;
    int          n_seen = 0;
    int          src_idle_pct;
    int          snk_idle_pct;
    int          wdog = 0;
    bit          timed_out = 1'b0;

    // signed (a*b)>>s with magnitude truncated
    function automatic longint mul_trunc(longint a, longint b, int s);
        bit                   neg;
        logic [63:0]          ua;
        logic [63:0]          ub;
        logic [127:0]         p;
        logic [63:0]          r;
        neg = (a < 0) != (b < 0);
        ua  = (a < 0) ? -a : a;
        ub  = (b < 0) ? -b : b;
        p   = {64'd0, ua} * {64'd0, ub};
        r   = 64'(p >> s);
        r[63] = 1'b0;
        return neg ? -longint'(r) : longint'(r);
    endfunction

    function automatic logic [31:0] exp_fp32(logic [31:0] x);
        logic [31:0] mag;
        bit          negx;
        int          ef;
        logic [63:0] sig;
        logic [63:0] mfix;
        logic [63:0] ln2f;
        logic [63:0] kmag;
        longint      r;
        longint      k;
        longint      total;
        longint      term;
        longint      inv;
        logic [63:0] us;
        int          sh;
        int          p;
        logic [22:0] mant;
        longint      e;
        mag  = {1'b0, x[30:0]};
        negx = x[31];
        if (mag > INF_BITS) return QNAN_BITS;
        if (mag == 0) return ONE_BITS;
        if (mag > F88_BITS) return negx ? 32'd0 : INF_BITS;
        ef  = mag[30:23];
        sig = {41'd0, mag[22:0]};
        if (ef != 0) sig[23] = 1'b1; else ef = 1;
        sh = ef - 150 + FRAC_BITS;
        if (sh >= 0) mfix = sig << sh;
        else if (-sh >= 64) mfix = 0;
        else mfix = sig >> (-sh);
        ln2f  = 64'h2C5C85FDF473DE6A >> (62 - FRAC_BITS);
        kmag  = (2 * mfix + ln2f) / (2 * ln2f);
        r     = longint'(mfix) - longint'(kmag * ln2f);
        k     = longint'(kmag);
        if (negx) begin
            r = -r;
            k = -k;
        end
        total = (longint'(1) << FRAC_BITS) + r;
        term  = r;
        for (int n = 2; n <= SERIES_TERMS; n++) begin
            inv   = longint'((64'd1 << 32) / n);
            term  = mul_trunc(term, r, FRAC_BITS);
            term  = mul_trunc(term, inv, 32);
            total += term;
        end
        if (total <= 0) return 32'd0;
        us = total;
        p  = 63;
        while (p > 0 && us[p] == 1'b0) p--;
        if (p >= 23) mant = 23'(us >> (p - 23));
        else mant = 23'(us << (23 - p));
        e = p - FRAC_BITS + 127 + k;
        if (e >= 255) return INF_BITS;
        if (e <= 0) return 32'd0;
        return {1'b0, 8'(e), mant};
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t ERROR %s: got %08h expected %08h", $realtime, what, got, want);
        n_err++;
    endtask

    // directed rows: value, expected (typed where obvious), flag to use the typed value over the prediction
    typedef struct {
        logic [31:0] x;
        logic [31:0] want;
        bit          typed;
    } t_row;

    t_row dir_tab [] = '{
        '{32'h0000_0000, ONE_BITS, 1}, '{32'h8000_0000, ONE_BITS, 1},
        '{32'h7FC0_0000, QNAN_BITS, 1}, '{32'hFFFF_FFFF, QNAN_BITS, 1},
        '{32'h7F80_0001, QNAN_BITS, 1}, '{32'h7F80_0000, INF_BITS, 1},
        '{32'hFF80_0000, 32'd0, 1}, '{32'h42B0_0001, INF_BITS, 1},
        '{32'hC2B0_0001, 32'd0, 1}, '{32'h7F7F_FFFF, INF_BITS, 1},
        '{32'hFF7F_FFFF, 32'd0, 1}, '{32'h0000_0001, ONE_BITS, 1},
        '{32'h807F_FFFF, ONE_BITS, 1}, '{32'h42B0_0000, 0, 0},
        '{32'hC2B0_0000, 0, 0}, '{32'h3F80_0000, 0, 0},
        '{32'hBF80_0000, 0, 0}, '{32'h3F31_7218, 0, 0},
        '{32'h3EB1_7218, 0, 0}, '{32'hBEB1_7218, 0, 0},
        '{32'h42AE_0000, 0, 0}, '{32'hC2AE_0000, 0, 0},
        '{32'h3000_0000, 0, 0}, '{32'h5555_5555, 0, 0},
        '{32'hAAAA_AAAA, 0, 0}
    };

    task automatic send_beat(logic [31:0] x, logic [31:0] want);
        while ($urandom_range(99) < src_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_x_bits <= x;
        exp_queue.push_back(want);
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        n_sent++;
    endtask

    function automatic logic [31:0] rand_x();
        logic [31:0] x;
        x = $urandom;
        case ($urandom_range(3))
            0: x[30:23] = 8'($urandom_range(100, 133));
            1: x[30:23] = 8'($urandom_range(120, 128));
            default: ;
        endcase
        return x;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= snk_idle_pct);
            if (o_valid && i_ready) begin
                n_seen++;
                if (exp_queue.size() == 0) begin
                    report_mismatch("unexpected beat", o_result_bits, 32'hx);
                end else begin
                    logic [31:0] w;
                    w = exp_queue.pop_front();
                    if (o_result_bits !== w) report_mismatch("result_bits", o_result_bits, w);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) wdog <= 0;
        else wdog <= wdog + 1;
        if (wdog >= WDOG_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("watchdog expired, %0d beats outstanding", exp_queue.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        logic [31:0] x;
        src_idle_pct = 11; snk_idle_pct = 73;
        i_rst_n <= 1'b0; i_valid <= 1'b0; i_x_bits <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (dir_tab[i])
            send_beat(dir_tab[i].x, dir_tab[i].typed ? dir_tab[i].want : exp_fp32(dir_tab[i].x));
        for (int ph = 0; ph < 3; ph++) begin
            src_idle_pct = (ph == 0) ? 11 : (ph == 1) ? 73 : 0;
            snk_idle_pct = (ph == 0) ? 73 : (ph == 1) ? 11 : 0;
            for (int i = 0; i < N_RANDOM / 3; i++) begin
                x = rand_x();
                send_beat(x, exp_fp32(x));
            end
        end
        i_valid <= 1'b0;
        while (exp_queue.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        $display("sent %0d arguments (specials, edges, random), checked %0d results",
                 n_sent, n_seen);
        if (n_err == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches", n_err);
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

FILE: filelist.f
hw/rtl/erx_pkg.sv
hw/rtl/exp_range_reduced_series.sv
hw/rtl/erx_chk.sv
tb/testbench.sv
